FILE: sv/dbpm_pkg.sv
// Shared types and constants for the dot-bracket pair matcher.
package dbpm_pkg;

    localparam int SYM_W           = 8;
    localparam int IDX_W           = 10;
    localparam int DEF_MAX_LEN     = 1024;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h28;
    localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h29;

    typedef enum logic [1:0] {
        OP_OTHER,
        OP_OPEN,
        OP_CLOSE,
        OP_TOO_LONG
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY_CLOSE,
        ST_UNCLOSED,
        ST_TOO_LONG
    } t_status;

endpackage

FILE: sv/dbpm_if.sv
// Valid/ready channel interfaces for characters in and pair results out.
interface dbpm_in_if;
    import dbpm_pkg::*;

    logic              valid;
    logic              ready;
    logic [SYM_W-1:0]  symbol;
    logic              is_last;

    modport source (output valid, output symbol, output is_last, input ready);
    modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

interface dbpm_out_if;
    import dbpm_pkg::*;

    logic              valid;
    logic              ready;
    logic              pair_valid;
    logic [IDX_W-1:0]  open_index;
    logic [IDX_W-1:0]  close_index;
    t_status           status;
    logic              end_of_string;

    modport source (output valid, output pair_valid, output open_index, output close_index,
                    output status, output end_of_string, input ready);
    modport sink   (input valid, input pair_valid, input open_index, input close_index,
                    input status, input end_of_string, output ready);
endinterface

FILE: sv/dbpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dbpm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/dbpm_fifo.sv
// Small flop-based queue between the classifier and the stack engine.
module dbpm_fifo #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_entry [DEPTH];
    logic [PtrW-1:0]  r_wptr, n_wptr;
    logic [PtrW-1:0]  r_rptr, n_rptr;
    logic [CntW-1:0]  r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + PtrW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CntW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_entry[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rptr];
endmodule

FILE: sv/dbpm_front.sv
// Front end: accept characters, number them and classify each into a stack operation.
module dbpm_front #(
    parameter int MAX_LEN = 1024
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    dbpm_in_if.sink                                        i_in,
    input  logic                                           i_full,
    output logic                                           o_push,
    output logic [$bits(dbpm_pkg::t_op)+$clog2(MAX_LEN):0] o_item
);
    import dbpm_pkg::*;

    localparam int StkW = $clog2(MAX_LEN);
    localparam int CntW = $clog2(MAX_LEN + 1);

    logic [CntW-1:0] r_pos, n_pos;
    logic            too_long;
    logic            accept;
    t_op             op;

    assign accept   = i_in.valid && !i_full;
    assign too_long = (r_pos >= CntW'(MAX_LEN));

    always_comb begin
        if (too_long) begin
            op = OP_TOO_LONG;
        end else begin
            case (i_in.symbol)
                SYM_OPEN:  op = OP_OPEN;
                SYM_CLOSE: op = OP_CLOSE;
                default:   op = OP_OTHER;
            endcase
        end
    end

    // Saturate at the length limit; restart numbering after the last character.
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_in.is_last) begin
                n_pos = '0;
            end else if (!too_long) begin
                n_pos = r_pos + CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign i_in.ready = !i_full;
    assign o_push     = accept;
    assign o_item     = {op, i_in.is_last, r_pos[StkW-1:0]};
endmodule

FILE: sv/dbpm_back.sv
// Back end: stack of open positions, pair reporting and the output register.
module dbpm_back #(
    parameter int MAX_LEN = 1024
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_q_valid,
    input  logic [$bits(dbpm_pkg::t_op)+$clog2(MAX_LEN):0] i_q_item,
    output logic                                           o_q_pop,
    dbpm_out_if.source                                     o_res
);
    import dbpm_pkg::*;

    localparam int StkW = $clog2(MAX_LEN);
    localparam int CntW = $clog2(MAX_LEN + 1);
    localparam int OpW  = $bits(t_op);
    localparam int ExtW = StkW + IDX_W;

    t_op              op;
    logic             last;
    logic [StkW-1:0]  pos;

    logic [CntW-1:0]  r_cnt, n_cnt;
    logic [StkW-1:0]  r_top, n_top;
    logic             r_top_in_ram, n_top_in_ram;
    logic [StkW-1:0]  top_eff;
    logic [StkW-1:0]  ram_q;
    logic             ram_we;
    logic [CntW-1:0]  waddr_full, raddr_full;

    logic             adv;
    logic             n_pair;
    logic [StkW-1:0]  n_oi, n_ci;
    t_status          n_status;
    logic [ExtW-1:0]  oi_ext, ci_ext;

    logic             r_valid;
    logic             r_pair;
    logic [IDX_W-1:0] r_oi, r_ci;
    t_status          r_status;
    logic             r_eos;

    assign op   = t_op'(i_q_item[OpW+StkW:StkW+1]);
    assign last = i_q_item[StkW];
    assign pos  = i_q_item[StkW-1:0];

    assign adv     = i_q_valid && (!r_valid || o_res.ready);
    assign o_q_pop = adv;

    // Entries below the top live in RAM; after a pop the new top arrives from
    // the read of count-2 issued in the popping cycle.
    assign top_eff    = r_top_in_ram ? ram_q : r_top;
    assign waddr_full = r_cnt - CntW'(1);
    assign raddr_full = r_cnt - CntW'(2);
    assign ram_we     = adv && (op == OP_OPEN) && (r_cnt != '0);

    always_comb begin
        n_cnt        = r_cnt;
        // Hold the read-back top in the register, as the RAM read moves on.
        n_top        = top_eff;
        n_top_in_ram = 1'b0;
        n_pair       = 1'b0;
        n_oi         = '0;
        n_ci         = '0;
        n_status     = ST_OK;
        if (adv) begin
            case (op)
                OP_OPEN: begin
                    n_top        = pos;
                    n_top_in_ram = 1'b0;
                    n_cnt        = r_cnt + CntW'(1);
                end
                OP_CLOSE: begin
                    if (r_cnt == '0) begin
                        n_status = ST_EMPTY_CLOSE;
                    end else begin
                        n_pair       = 1'b1;
                        n_oi         = top_eff;
                        n_ci         = pos;
                        n_cnt        = r_cnt - CntW'(1);
                        n_top_in_ram = 1'b1;
                    end
                end
                OP_TOO_LONG: n_status = ST_TOO_LONG;
                default:     n_status = ST_OK;
            endcase
            if (last) begin
                if (n_status == ST_OK && n_cnt != '0) begin
                    n_status = ST_UNCLOSED;
                end
                n_cnt        = '0;
                n_top_in_ram = 1'b0;
            end
        end
    end

    assign oi_ext = ExtW'(n_oi);
    assign ci_ext = ExtW'(n_ci);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_top_in_ram <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_cnt        <= n_cnt;
            r_top_in_ram <= n_top_in_ram;
            if (adv) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
        r_top <= n_top;
        if (adv) begin
            r_pair   <= n_pair;
            r_oi     <= oi_ext[IDX_W-1:0];
            r_ci     <= ci_ext[IDX_W-1:0];
            r_status <= n_status;
            r_eos    <= last;
        end
    end

    dbpm_ram #(
        .WIDTH (StkW),
        .DEPTH (MAX_LEN)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr_full[StkW-1:0]),
        .i_wdata (top_eff),
        .i_raddr (raddr_full[StkW-1:0]),
        .o_rdata (ram_q)
    );

    assign o_res.valid         = r_valid;
    assign o_res.pair_valid    = r_pair;
    assign o_res.open_index    = r_oi;
    assign o_res.close_index   = r_ci;
    assign o_res.status        = r_status;
    assign o_res.end_of_string = r_eos;
endmodule

FILE: sv/dot_bracket_pair_matcher.sv
// Top level: dot-bracket pair matcher, one character word in, one result word out.
// Path: a character word accepted at the input is registered in the queue, then in the
// output register; output stalls keep it waiting in the queue.
// Throughput: one word per cycle while the output is taken, set by a single stack push or pop in the back end.
// The stack top sits in a register; the RAM below it is read one entry ahead.
// Reset (synchronous, active low) clears position, stack depth, queue and output valid;
// stack RAM contents are left as they are and are never read before being written.
module dot_bracket_pair_matcher #(
    parameter int MAX_LEN     = dbpm_pkg::DEF_MAX_LEN,
    parameter int QUEUE_DEPTH = dbpm_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dbpm_in_if.sink     i_in,
    dbpm_out_if.source  o_res
);
    import dbpm_pkg::*;

    // Queue word: operation, last flag, position of the character.
    localparam int ItemW = $bits(t_op) + 1 + $clog2(MAX_LEN);

    logic             q_push;
    logic             q_full;
    logic [ItemW-1:0] q_in_item;
    logic             q_pop;
    logic             q_valid;
    logic [ItemW-1:0] q_out_item;

    // Number and classify characters; hold the input while the queue is full.
    dbpm_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_item  (q_in_item)
    );

    // Decouple classification from the stack so each side stalls on its own.
    dbpm_fifo #(
        .WIDTH (ItemW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out_item)
    );

    // Push, pop and report pairs; advance only when the output register frees up.
    dbpm_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_out_item),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );
endmodule
